// File: hw/rtl/qwt_pkg.sv
package qwt_pkg;

   localparam int BYTE_BITS  = 8;
   localparam int LIMIT_BITS = 10;
   localparam int RES_MAX    = 3;
   localparam int CNT_BITS   = $clog2(RES_MAX + 1);

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 10'd1023;

   localparam logic [BYTE_BITS-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [BYTE_BITS-1:0] CHAR_TAB    = 8'h09;
   localparam logic [BYTE_BITS-1:0] CHAR_DQUOTE = 8'h22;
   localparam logic [BYTE_BITS-1:0] CHAR_SQUOTE = 8'h27;
   localparam logic [BYTE_BITS-1:0] CHAR_BSLASH = 8'h5C;
   localparam logic [BYTE_BITS-1:0] CHAR_CR     = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CHAR_LF     = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CHAR_LOW_R  = 8'h72;
   localparam logic [BYTE_BITS-1:0] CHAR_LOW_N  = 8'h6E;
   localparam logic [BYTE_BITS-1:0] CHAR_LOW_T  = 8'h74;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_BARE   = 4'b0010,
      MODE_DQUOTE = 4'b0100,
      MODE_SQUOTE = 4'b1000
   } mode_type;

   typedef struct packed {
      logic                 has_char;
      logic [BYTE_BITS-1:0] out_char;
      logic                 word_end;
      logic                 run_last;
   } rsp_item_type;

   typedef struct packed {
      logic [CNT_BITS-1:0]        cnt;
      rsp_item_type [RES_MAX-1:0] res;
   } rsp_list_type;

   typedef struct packed {
      logic [CNT_BITS-1:0] count;
      logic                can_load;
   } buf_status_type;

endpackage

// File: hw/rtl/qwt_if.sv
interface qwt_req_if;
   import qwt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] in_byte;
   logic                 string_end;
   modport source (output valid, output in_byte, output string_end, input ready);
   modport sink (input valid, input in_byte, input string_end, output ready);
endinterface

interface qwt_rsp_if;
   import qwt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 has_char;
   logic [BYTE_BITS-1:0] out_char;
   logic                 word_end;
   logic                 run_last;
   modport source (output valid, output has_char, output out_char, output word_end,
                   output run_last, input ready);
   modport sink (input valid, input has_char, input out_char, input word_end,
                 input run_last, output ready);
endinterface

interface qwt_csr_if;
   import qwt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [LIMIT_BITS-1:0] word_limit;
   modport source (output valid, output word_limit, input ready);
   modport sink (input valid, input word_limit, output ready);
endinterface

// File: hw/rtl/qwt_lexer.sv
module qwt_lexer #(
   parameter int LEN_BITS = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic [qwt_pkg::BYTE_BITS-1:0]  in_byte,
   input  logic                           string_end,
   input  logic [qwt_pkg::LIMIT_BITS-1:0] word_limit,
   output qwt_pkg::rsp_list_type          rsp_list
);
   import qwt_pkg::*;

   localparam int CMP_BITS = (LEN_BITS > LIMIT_BITS) ? LEN_BITS : LIMIT_BITS;

   typedef struct packed {
      mode_type            mode;
      logic                esc;
      logic [LEN_BITS-1:0] len;
      rsp_list_type        list;
   } work_type;

   mode_type            mode_ff, mode_in;
   logic                esc_ff, esc_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic [CMP_BITS-1:0] lim_wide;
   logic [CMP_BITS-1:0] cap_wide;
   logic [LEN_BITS-1:0] lim;
   work_type            step_w;

   function automatic work_type f_push(work_type w, logic hc, logic [BYTE_BITS-1:0] ch,
                                       logic we);
      work_type r;
      r = w;
      if (w.list.cnt != CNT_BITS'(RES_MAX)) begin
         r.list.res[w.list.cnt] = '{has_char: hc, out_char: ch, word_end: we,
                                    run_last: 1'b0};
         r.list.cnt = w.list.cnt + CNT_BITS'(1);
      end
      return r;
   endfunction

   function automatic work_type f_end_word(work_type w);
      work_type            r;
      logic [CNT_BITS-1:0] top_idx;
      r = w;
      top_idx = w.list.cnt - CNT_BITS'(1);
      if (w.list.cnt != '0 && w.list.res[top_idx].has_char &&
          !w.list.res[top_idx].word_end) begin
         r.list.res[top_idx].word_end = 1'b1;
      end else begin
         r = f_push(w, 1'b0, '0, 1'b1);
      end
      r.mode = MODE_IDLE;
      r.len  = '0;
      r.esc  = 1'b0;
      return r;
   endfunction

   function automatic work_type f_emit(work_type w, logic [BYTE_BITS-1:0] ch,
                                       logic [LEN_BITS-1:0] lim_val);
      work_type r;
      r = f_push(w, 1'b1, ch, 1'b0);
      r.len = w.len + LEN_BITS'(1);
      if (r.len >= lim_val) begin
         r = f_end_word(r);
      end
      return r;
   endfunction

   function automatic work_type f_plain(work_type w, logic [BYTE_BITS-1:0] b,
                                        logic [LEN_BITS-1:0] lim_val);
      work_type             r;
      logic                 sep;
      logic [BYTE_BITS-1:0] q;
      r = w;
      sep = (b == CHAR_SPACE) || (b == CHAR_TAB);
      q = (w.mode == MODE_DQUOTE) ? CHAR_DQUOTE : CHAR_SQUOTE;
      case (w.mode)
         MODE_IDLE: begin
            if (sep) begin
               r = w;
            end else if (b == CHAR_DQUOTE) begin
               r.mode = MODE_DQUOTE;
            end else if (b == CHAR_SQUOTE) begin
               r.mode = MODE_SQUOTE;
            end else begin
               r.mode = MODE_BARE;
               r = f_emit(r, b, lim_val);
            end
         end
         MODE_BARE: begin
            if (sep) begin
               r = f_end_word(w);
            end else if (b == CHAR_DQUOTE) begin
               r = f_end_word(w);
               r.mode = MODE_DQUOTE;
            end else begin
               r = f_emit(w, b, lim_val);
            end
         end
         default: begin
            if (b == q) begin
               r = f_end_word(w);
            end else if (b == CHAR_BSLASH) begin
               r.esc = 1'b1;
            end else begin
               r = f_emit(w, b, lim_val);
            end
         end
      endcase
      return r;
   endfunction

   function automatic work_type f_escaped(work_type w, logic [BYTE_BITS-1:0] b,
                                          logic [LEN_BITS-1:0] lim_val);
      work_type             r;
      logic [BYTE_BITS-1:0] q;
      r = w;
      r.esc = 1'b0;
      q = (w.mode == MODE_DQUOTE) ? CHAR_DQUOTE : CHAR_SQUOTE;
      if (b == q || b == CHAR_BSLASH) begin
         r = f_emit(r, b, lim_val);
      end else if (b == CHAR_LOW_R) begin
         r = f_emit(r, CHAR_CR, lim_val);
      end else if (b == CHAR_LOW_N) begin
         r = f_emit(r, CHAR_LF, lim_val);
      end else if (b == CHAR_LOW_T) begin
         r = f_emit(r, CHAR_TAB, lim_val);
      end else begin
         r = f_emit(r, CHAR_BSLASH, lim_val);
         r = f_plain(r, b, lim_val);
      end
      return r;
   endfunction

   always_comb begin
      lim_wide = CMP_BITS'(word_limit);
      cap_wide = CMP_BITS'({LEN_BITS{1'b1}});
      if (lim_wide == '0) begin
         lim_wide = CMP_BITS'(1);
      end
      if (lim_wide > cap_wide) begin
         lim_wide = cap_wide;
      end
      lim = lim_wide[LEN_BITS-1:0];
   end

   always_comb begin
      step_w.mode     = mode_ff;
      step_w.esc      = esc_ff;
      step_w.len      = len_ff;
      step_w.list.cnt = '0;
      step_w.list.res = '0;
      if (esc_ff && (mode_ff == MODE_DQUOTE || mode_ff == MODE_SQUOTE)) begin
         step_w = f_escaped(step_w, in_byte, lim);
      end else begin
         step_w.esc = 1'b0;
         step_w = f_plain(step_w, in_byte, lim);
      end
      if (string_end) begin
         if (step_w.mode != MODE_IDLE) begin
            step_w = f_end_word(step_w);
         end
         step_w.mode = MODE_IDLE;
         step_w.esc  = 1'b0;
         step_w.len  = '0;
      end
      if (step_w.list.cnt != '0) begin
         step_w.list.res[step_w.list.cnt - CNT_BITS'(1)].run_last = 1'b1;
      end
   end

   assign rsp_list = step_w.list;

   always_comb begin
      mode_in = mode_ff;
      esc_in  = esc_ff;
      len_in  = len_ff;
      if (advance) begin
         mode_in = step_w.mode;
         esc_in  = step_w.esc;
         len_in  = step_w.len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         esc_ff  <= 1'b0;
         len_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         esc_ff  <= esc_in;
         len_ff  <= len_in;
      end
   end

endmodule

// File: hw/rtl/qwt_rsp_buffer.sv
module qwt_rsp_buffer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  qwt_pkg::rsp_list_type   load_list,
   input  logic                    pop,
   output qwt_pkg::rsp_item_type   head,
   output qwt_pkg::buf_status_type status
);
   import qwt_pkg::*;

   rsp_item_type [RES_MAX-1:0] ent_ff, ent_in;
   logic [CNT_BITS-1:0]        count_ff, count_in;

   always_comb begin
      ent_in   = ent_ff;
      count_in = count_ff;
      if (load) begin
         ent_in   = load_list.res;
         count_in = load_list.cnt;
      end else if (pop) begin
         for (int i = 0; i < RES_MAX - 1; i++) begin
            ent_in[i] = ent_ff[i + 1];
         end
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head            = ent_ff[0];
   assign status.count    = count_ff;
   assign status.can_load = (count_ff == '0) || (count_ff == CNT_BITS'(1) && pop);

endmodule

// File: hw/rtl/quoted_word_tokenizer_unit.sv
// Channel  Role     Payload
// req      sink     in_byte, string_end
// rsp      source   has_char, out_char, word_end, run_last
// csr      sink     word_limit
//
// One byte per cycle while rsp.ready is high and each byte yields at most one
// result; a byte that yields n results holds the input while the three-entry
// result buffer drains. Bytes pass the input register and then the result buffer.
// Reset is synchronous and restores the between-words state and a limit of 1023.
// A stalled response side backs up into the input register and then drops req.ready.
module quoted_word_tokenizer_unit #(
   parameter int LEN_BITS = 10
) (
   input logic       clock,
   input logic       reset,
   qwt_req_if.sink   req,
   qwt_rsp_if.source rsp,
   qwt_csr_if.sink   csr
);
   import qwt_pkg::*;

   logic                  item_valid_ff, item_valid_in;
   logic [BYTE_BITS-1:0]  item_byte_ff;
   logic                  item_end_ff;
   logic [LIMIT_BITS-1:0] limit_ff, limit_in;
   logic                  advance;
   logic                  pop;
   rsp_list_type          step_list;
   rsp_item_type          head;
   buf_status_type        buf_status;

   assign pop       = rsp.valid && rsp.ready;
   assign advance   = item_valid_ff && buf_status.can_load;
   assign req.ready = !item_valid_ff || advance;
   assign csr.ready = 1'b1;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req.valid && req.ready) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
      limit_in = limit_ff;
      if (csr.valid && csr.ready) begin
         limit_in = csr.word_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         item_byte_ff <= req.in_byte;
         item_end_ff  <= req.string_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         limit_ff      <= LIMIT_RESET;
      end else begin
         item_valid_ff <= item_valid_in;
         limit_ff      <= limit_in;
      end
   end

   qwt_lexer #(
      .LEN_BITS(LEN_BITS)
   ) u_lexer (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_byte    (item_byte_ff),
      .string_end (item_end_ff),
      .word_limit (limit_ff),
      .rsp_list   (step_list)
   );

   qwt_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_list (step_list),
      .pop       (pop),
      .head      (head),
      .status    (buf_status)
   );

   assign rsp.valid    = (buf_status.count != '0);
   assign rsp.has_char = head.has_char;
   assign rsp.out_char = head.out_char;
   assign rsp.word_end = head.word_end;
   assign rsp.run_last = head.run_last;

`ifndef SYNTH
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !advance) |=> item_valid_ff)
      else $error("Pending input transaction was lost.");

   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && buf_status.count == CNT_BITS'(1)) |-> rsp.run_last)
      else $error("Final response of an item lacks run_last.");

   a_inner_unmarked: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && buf_status.count > CNT_BITS'(1)) |-> !rsp.run_last)
      else $error("run_last set on a response that is not the final one.");
`endif

endmodule

// File: test/tb_quoted_word_tokenizer_unit.sv
`timescale 1ns / 1ps

module tb_quoted_word_tokenizer_unit;
   import qwt_pkg::*;

   localparam int WORD_LEN_BITS  = 10;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 80;

   typedef enum logic {ROW_BYTE, ROW_LIMIT} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [BYTE_BITS-1:0]  in_byte;
      logic                  string_end;
      logic [LIMIT_BITS-1:0] limit;
      int                    known_cnt;
      rsp_item_type          known_res;
   } dir_row_type;

   typedef struct packed {
      logic                 last;
      logic [BYTE_BITS-1:0] data;
   } stim_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qwt_req_if req_ch ();
   qwt_rsp_if rsp_ch ();
   qwt_csr_if csr_ch ();

   quoted_word_tokenizer_unit #(
      .LEN_BITS(WORD_LEN_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch),
      .csr  (csr_ch)
   );

   always #5 clock = ~clock;

   logic [LIMIT_BITS-1:0]    model_limit  = LIMIT_RESET;
   mode_type                 model_mode   = MODE_IDLE;
   logic                     model_escape = 1'b0;
   logic [WORD_LEN_BITS-1:0] model_len    = '0;
   rsp_item_type             step_res[RES_MAX];
   int                       step_cnt;

   rsp_item_type  expected_q[$];
   stim_byte_type cmd_q[$];
   dir_row_type   dir_rows[$];

   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int req_gap_pct    = 12;
   int rsp_gap_pct    = 56;
   int hold_ticket    = 0;

   function automatic int active_limit();
      int lim;
      lim = model_limit;
      if (lim == 0) lim = 1;
      if (lim > (1 << WORD_LEN_BITS) - 1) lim = (1 << WORD_LEN_BITS) - 1;
      return lim;
   endfunction

   function automatic void note_result(logic hc, logic [BYTE_BITS-1:0] ch, logic we);
      if (step_cnt < RES_MAX) begin
         step_res[step_cnt].has_char = hc;
         step_res[step_cnt].out_char = ch;
         step_res[step_cnt].word_end = we;
         step_res[step_cnt].run_last = 1'b0;
         step_cnt++;
      end
   endfunction

   // A word end folds into the last character of this byte when that one is still open.
   function automatic void close_word();
      if (step_cnt > 0 && step_res[step_cnt-1].has_char && !step_res[step_cnt-1].word_end)
         step_res[step_cnt-1].word_end = 1'b1;
      else
         note_result(1'b0, '0, 1'b1);
      model_mode   = MODE_IDLE;
      model_len    = '0;
      model_escape = 1'b0;
   endfunction

   function automatic void put_char(logic [BYTE_BITS-1:0] ch);
      note_result(1'b1, ch, 1'b0);
      model_len = model_len + 1'b1;
      if (model_len >= active_limit()) close_word();
   endfunction

   function automatic void plain_char(logic [BYTE_BITS-1:0] b);
      logic [BYTE_BITS-1:0] quote;
      case (model_mode)
         MODE_IDLE: begin
            if (b == CHAR_SPACE || b == CHAR_TAB) begin
            end else if (b == CHAR_DQUOTE) begin
               model_mode = MODE_DQUOTE;
            end else if (b == CHAR_SQUOTE) begin
               model_mode = MODE_SQUOTE;
            end else begin
               model_mode = MODE_BARE;
               put_char(b);
            end
         end
         MODE_BARE: begin
            if (b == CHAR_SPACE || b == CHAR_TAB) begin
               close_word();
            end else if (b == CHAR_DQUOTE) begin
               close_word();
               model_mode = MODE_DQUOTE;
            end else begin
               put_char(b);
            end
         end
         default: begin
            quote = (model_mode == MODE_DQUOTE) ? CHAR_DQUOTE : CHAR_SQUOTE;
            if (b == quote) close_word();
            else if (b == CHAR_BSLASH) model_escape = 1'b1;
            else put_char(b);
         end
      endcase
   endfunction

   function automatic void escaped_char(logic [BYTE_BITS-1:0] b);
      logic [BYTE_BITS-1:0] quote;
      quote = (model_mode == MODE_DQUOTE) ? CHAR_DQUOTE : CHAR_SQUOTE;
      model_escape = 1'b0;
      if (b == quote || b == CHAR_BSLASH) begin
         put_char(b);
      end else if (b == CHAR_LOW_R) begin
         put_char(CHAR_CR);
      end else if (b == CHAR_LOW_N) begin
         put_char(CHAR_LF);
      end else if (b == CHAR_LOW_T) begin
         put_char(CHAR_TAB);
      end else begin
         put_char(CHAR_BSLASH);
         plain_char(b);
      end
   endfunction

   function automatic void tokenize_byte(logic [BYTE_BITS-1:0] b, logic last);
      step_cnt = 0;
      if (model_escape && (model_mode == MODE_DQUOTE || model_mode == MODE_SQUOTE)) begin
         escaped_char(b);
      end else begin
         model_escape = 1'b0;
         plain_char(b);
      end
      if (last) begin
         if (model_mode != MODE_IDLE) close_word();
         model_mode   = MODE_IDLE;
         model_escape = 1'b0;
         model_len    = '0;
      end
      if (step_cnt > 0) step_res[step_cnt-1].run_last = 1'b1;
   endfunction

   function automatic dir_row_type byte_row(logic [BYTE_BITS-1:0] b, logic last);
      dir_row_type r;
      r.kind       = ROW_BYTE;
      r.in_byte    = b;
      r.string_end = last;
      r.limit      = '0;
      r.known_cnt  = -1;
      r.known_res  = '0;
      return r;
   endfunction

   function automatic dir_row_type known_row(logic [BYTE_BITS-1:0] b, logic last, int cnt,
                                             logic hc, logic [BYTE_BITS-1:0] ch);
      dir_row_type r;
      r = byte_row(b, last);
      r.known_cnt          = cnt;
      r.known_res.has_char = hc;
      r.known_res.out_char = ch;
      r.known_res.word_end = 1'b1;
      r.known_res.run_last = 1'b1;
      return r;
   endfunction

   function automatic dir_row_type limit_row(logic [LIMIT_BITS-1:0] v);
      dir_row_type r;
      r = byte_row('0, 1'b0);
      r.kind  = ROW_LIMIT;
      r.limit = v;
      return r;
   endfunction

   function automatic void add_byte(logic [BYTE_BITS-1:0] b);
      stim_byte_type s;
      s.last = 1'b0;
      s.data = b;
      cmd_q.push_back(s);
   endfunction

   function automatic logic [BYTE_BITS-1:0] word_char();
      if ($urandom_range(0, 3) != 0) return 8'h61 + 8'($urandom_range(0, 25));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void add_quoted(logic [BYTE_BITS-1:0] quote);
      int n;
      int k;
      n = $urandom_range(0, 6);
      add_byte(quote);
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 3) == 0) begin
            add_byte(CHAR_BSLASH);
            case ($urandom_range(0, 5))
               0: add_byte(quote);
               1: add_byte(CHAR_BSLASH);
               2: add_byte(CHAR_LOW_R);
               3: add_byte(CHAR_LOW_N);
               4: add_byte(CHAR_LOW_T);
               default: add_byte(word_char());
            endcase
         end else begin
            add_byte(word_char());
         end
      end
      if ($urandom_range(0, 5) != 0) add_byte(quote);
   endfunction

   // Mostly complete command strings; one in five is raw noise with random string ends.
   function automatic void build_command();
      int n_tok;
      int t;
      int k;
      int n;
      stim_byte_type tail;
      if ($urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 10);
         for (k = 0; k < n; k++) begin
            tail.data = 8'($urandom_range(0, 255));
            tail.last = ($urandom_range(0, 5) == 0);
            cmd_q.push_back(tail);
         end
         return;
      end
      n_tok = $urandom_range(1, 5);
      for (t = 0; t < n_tok; t++) begin
         case ($urandom_range(0, 4))
            0, 1: begin
               n = $urandom_range(1, 9);
               for (k = 0; k < n; k++) add_byte(word_char());
            end
            2: add_quoted(CHAR_DQUOTE);
            3: add_quoted(CHAR_SQUOTE);
            default: begin
               n = $urandom_range(1, 4);
               for (k = 0; k < n; k++) add_byte(word_char());
               add_quoted(CHAR_DQUOTE);
            end
         endcase
         n = $urandom_range(0, 2);
         for (k = 0; k < n; k++) add_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
      end
      if ($urandom_range(0, 7) == 0) add_byte(CHAR_BSLASH);
      tail = cmd_q.pop_back();
      tail.last = 1'b1;
      cmd_q.push_back(tail);
   endfunction

   task automatic send_byte(input logic [BYTE_BITS-1:0] b, input logic last,
                            input int known_cnt, input rsp_item_type known_res);
      int k;
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.in_byte    <= b;
      req_ch.string_end <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tokenize_byte(b, last);
      if (known_cnt < 0) begin
         for (k = 0; k < step_cnt; k++) expected_q.push_back(step_res[k]);
      end else if (known_cnt > 0) begin
         expected_q.push_back(known_res);
      end
      @(negedge clock);
   endtask

   // A byte with no result may still be in flight when the queue empties, so wait
   // before the write.
   task automatic write_limit(input logic [LIMIT_BITS-1:0] v);
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_ch.valid      <= 1'b1;
      csr_ch.word_limit <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      model_limit = v;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [BYTE_BITS-1:0] want,
                              input logic [BYTE_BITS-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, got char %0h end %0b",
                     $time, rsp_ch.out_char, rsp_ch.word_end);
            mismatch_count++;
         end else begin
            want = expected_q.pop_front();
            check_field("has_char", want.has_char, rsp_ch.has_char);
            check_field("out_char", want.out_char, rsp_ch.out_char);
            check_field("word_end", want.word_end, rsp_ch.word_end);
            check_field("run_last", want.run_last, rsp_ch.run_last);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
         $display("quoted_word_tokenizer_unit test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : result_sink
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_gap_pct);
         end
      end
   end

   initial begin : stimulus
      int i;
      int seg;
      int sent;
      int seg_limits[9];
      stim_byte_type cur;
      req_ch.valid      = 1'b0;
      req_ch.in_byte    = '0;
      req_ch.string_end = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.word_limit = '0;

      dir_rows.push_back(known_row(8'h00, 1'b1, 1, 1'b1, 8'h00));
      dir_rows.push_back(known_row(8'hFF, 1'b1, 1, 1'b1, 8'hFF));
      dir_rows.push_back(known_row(CHAR_SPACE, 1'b1, 0, 1'b0, 8'h00));
      dir_rows.push_back(known_row(CHAR_DQUOTE, 1'b1, 1, 1'b0, 8'h00));
      dir_rows.push_back(byte_row("a", 1'b0));
      dir_rows.push_back(byte_row(CHAR_SQUOTE, 1'b0));
      dir_rows.push_back(byte_row(CHAR_DQUOTE, 1'b0));
      dir_rows.push_back(byte_row(CHAR_BSLASH, 1'b0));
      dir_rows.push_back(byte_row(CHAR_DQUOTE, 1'b0));
      dir_rows.push_back(byte_row(CHAR_BSLASH, 1'b0));
      dir_rows.push_back(byte_row(CHAR_LOW_N, 1'b0));
      dir_rows.push_back(byte_row(CHAR_BSLASH, 1'b0));
      dir_rows.push_back(byte_row("q", 1'b0));
      dir_rows.push_back(byte_row(CHAR_DQUOTE, 1'b0));
      dir_rows.push_back(byte_row(CHAR_SQUOTE, 1'b0));
      dir_rows.push_back(known_row(CHAR_SQUOTE, 1'b0, 1, 1'b0, 8'h00));
      dir_rows.push_back(byte_row(CHAR_SQUOTE, 1'b0));
      dir_rows.push_back(byte_row(CHAR_BSLASH, 1'b1));
      dir_rows.push_back(limit_row(10'd0));
      dir_rows.push_back(byte_row(CHAR_DQUOTE, 1'b0));
      dir_rows.push_back(byte_row("y", 1'b0));
      dir_rows.push_back(byte_row(CHAR_DQUOTE, 1'b1));
      dir_rows.push_back(limit_row(10'd1023));
      dir_rows.push_back(byte_row("a", 1'b0));
      dir_rows.push_back(byte_row("b", 1'b0));
      dir_rows.push_back(limit_row(10'd2));
      dir_rows.push_back(known_row("c", 1'b1, 1, 1'b1, "c"));
      dir_rows.push_back(byte_row(CHAR_TAB, 1'b1));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < dir_rows.size(); i++) begin
         if (dir_rows[i].kind == ROW_LIMIT)
            write_limit(dir_rows[i].limit);
         else
            send_byte(dir_rows[i].in_byte, dir_rows[i].string_end,
                      dir_rows[i].known_cnt, dir_rows[i].known_res);
      end

      seg_limits = '{1023, 1, 4, 0, 2, 7, 1023, 3, 0};
      seg_limits[8] = $urandom_range(0, 1023);
      for (seg = 0; seg < 9; seg++) begin
         case (seg / 3)
            0: begin
               req_gap_pct = 12;
               rsp_gap_pct = 56;
            end
            1: begin
               req_gap_pct = 56;
               rsp_gap_pct = 12;
            end
            default: begin
               req_gap_pct = 0;
               rsp_gap_pct = 0;
            end
         endcase
         write_limit(LIMIT_BITS'(seg_limits[seg]));
         if (seg == 6) hold_ticket++;
         sent = 0;
         while (sent < 24) begin
            build_command();
            while (cmd_q.size() != 0) begin
               cur = cmd_q.pop_front();
               send_byte(cur.data, cur.last, -1, '0);
               sent++;
            end
         end
      end

      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_q.size() == 0)
         $display("quoted_word_tokenizer_unit test passed");
      else
         $display("quoted_word_tokenizer_unit test failed");
      $finish;
   end

endmodule
